/* hdl/bfa_pkg.sv */
`default_nettype none

package bfa_pkg;

  localparam int WORD_BITS          = 32;
  localparam int MAX_FRAMES_DEFAULT = 4096;
  localparam int WORD_COUNT_DEFAULT = (MAX_FRAMES_DEFAULT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW_DEFAULT    = $clog2(WORD_COUNT_DEFAULT);

  localparam logic [WORD_BITS-1:0] ALL_USED = 32'hFFFF_FFFF;

  localparam logic [4:0]  PAGE_SHIFT_RESET  = 5'd12;
  localparam logic [12:0] FRAME_LIMIT_RESET = 13'd4096;

  localparam logic [2:0] MODE_ALLOC    = 3'd0;
  localparam logic [2:0] MODE_FREE     = 3'd1;
  localparam logic [2:0] MODE_RESERVE  = 3'd2;
  localparam logic [2:0] MODE_RELEASE  = 3'd3;
  localparam logic [2:0] MODE_MARK_ALL = 3'd4;

  localparam logic REG_PAGE_SHIFT  = 1'b0;
  localparam logic REG_FRAME_LIMIT = 1'b1;

  typedef struct packed {
    logic [4:0]  page_shift;
    logic [12:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] frame_address;
    logic        out_of_memory;
  } res_t;

  // Index of the lowest clear bit; only meaningful when some bit is clear.
  function automatic logic [4:0] lowest_zero(input logic [WORD_BITS-1:0] w);
    logic [4:0] idx;
    idx = 5'd0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        idx = 5'(b);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* hdl/bitmap_frame_allocator.sv */
// Channel   Direction  Handshake           Payload
// config    in         psel/penable/pready paddr, pwdata, pwrite -> prdata
// command   in         in_valid/in_stall   mode, address, length
// result    out        out_valid/out_stall frame_address, out_of_memory, done_res
//
// One command is worked on at a time; the single read port of the bitmap RAM sets the pace.
// Allocate: scans from word 0 up to the first word with a free frame (one word per cycle).
// Free, reserve, release: one read-modify-write per bitmap word that the region covers.
// Mark all used: writes every bitmap word. After reset, a fill pass over every bitmap word
// (128 at the default size) sets every frame used while in_stall stays high.
// A result waiting in the output register does not hold off the next command.
`default_nettype none

module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [31:0] address,
  input  logic [31:0] length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] frame_address,
  output logic        out_of_memory,
  output logic        done_res
);

  cfg_t cfg;
  res_t res;
  logic res_valid, res_ready, cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_shift  <= PAGE_SHIFT_RESET;
      cfg.frame_limit <= FRAME_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PAGE_SHIFT:  cfg.page_shift  <= pwdata[4:0];
        REG_FRAME_LIMIT: cfg.frame_limit <= pwdata[12:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PAGE_SHIFT:  prdata = {27'd0, cfg.page_shift};
      REG_FRAME_LIMIT: prdata = {19'd0, cfg.frame_limit};
    endcase
  end

  bfa_engine #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .address   (address),
    .length    (length),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid || !out_stall;
  assign done_res  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      frame_address <= res.frame_address;
      out_of_memory <= res.out_of_memory;
    end
  end

endmodule

`default_nettype wire

/* hdl/bfa_ram.sv */
`default_nettype none

module bfa_ram
  import bfa_pkg::*;
#(
  parameter int DEPTH = WORD_COUNT_DEFAULT,
  parameter int AW    = WORD_AW_DEFAULT
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/bfa_engine.sv */
`default_nettype none

module bfa_engine
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [31:0] address,
  input  logic [31:0] length,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WCW        = $clog2(WORD_COUNT + 1);
  localparam int FW         = $clog2(MAX_FRAMES + 1);

  localparam logic [WIW-1:0] LAST_WORD = WIW'(WORD_COUNT - 1);
  localparam logic [FW-1:0]  MAX_END   = FW'(MAX_FRAMES);

  localparam logic [2:0] S_FILL   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_SPAN   = 3'd3;
  localparam logic [2:0] S_BOUNDS = 3'd4;
  localparam logic [2:0] S_RANGE  = 3'd5;
  localparam logic [2:0] S_ALLOC  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]  state, state_next;
  logic [2:0]  mode_r;
  logic [31:0] addr_r, len_r;
  logic [31:0] first_r;
  logic [32:0] count_r;
  logic [FW-1:0] end_r;
  logic [WIW-1:0] first_word, last_word, wi, chk;
  logic [4:0]  lo_bit, hi_bit;
  logic [WCW-1:0] scan, words_r;
  logic        rd_pend, found, oom, fill_ack;
  logic [WIW+4:0] found_frame;

  logic                 ram_wr_en, ram_rd_en;
  logic [WIW-1:0]       ram_wr_addr, ram_rd_addr;
  logic [WORD_BITS-1:0] ram_wr_data, ram_rd_data;

  logic [12:0]    limit;
  logic [13:0]    limit_up;
  logic [WCW-1:0] words_calc;
  logic [WIW-1:0] fw_calc;
  logic [FW-1:0]  last_frame;
  logic [33:0]    end_sum;
  logic [4:0]     lo_eff, hi_eff, zb;
  logic [31:0]    range_mask, page_mask;
  logic           chk_last, word_free;

  bfa_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (WIW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Allocation scans whole words that cover min(frame_limit, MAX_FRAMES) frames.
  assign limit      = (32'(cfg.frame_limit) > 32'(MAX_FRAMES)) ? 13'(MAX_FRAMES)
                                                                : cfg.frame_limit;
  assign limit_up   = {1'b0, limit} + 14'd31;
  assign words_calc = WCW'(limit_up >> 5);

  assign fw_calc    = WIW'(first_r >> 5);
  assign last_frame = end_r - FW'(1);
  assign end_sum    = {2'b00, first_r} + {1'b0, count_r};
  assign page_mask  = ~(ALL_USED << cfg.page_shift);

  assign lo_eff     = (wi == first_word) ? lo_bit : 5'd0;
  assign hi_eff     = (wi == last_word) ? hi_bit : 5'd31;
  assign range_mask = (ALL_USED << lo_eff) & (ALL_USED >> (5'd31 - hi_eff));

  assign zb        = lowest_zero(ram_rd_data);
  assign word_free = rd_pend && (ram_rd_data != ALL_USED);
  assign chk_last  = (chk == WIW'(words_r - WCW'(1)));

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.out_of_memory = oom;
  assign res.frame_address = found ? (32'(found_frame) << cfg.page_shift) : 32'd0;

  // Reads and writes of one command never touch the same word in the same
  // cycle, and a following command issues its first read only after the
  // engine has passed through S_IDLE, so the sequencing itself keeps the memory coherent.
  always_comb begin
    state_next  = state;
    ram_wr_en   = 1'b0;
    ram_wr_addr = wi;
    ram_wr_data = ALL_USED;
    ram_rd_en   = 1'b0;
    ram_rd_addr = wi;
    unique case (state)
      S_FILL: begin
        ram_wr_en = 1'b1;
        if (wi == LAST_WORD) begin
          state_next = fill_ack ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (mode) inside
            MODE_ALLOC:                           state_next = S_ALLOC;
            MODE_FREE, MODE_RESERVE, MODE_RELEASE: state_next = S_PREP;
            MODE_MARK_ALL:                        state_next = S_FILL;
            default:                              state_next = S_DONE;
          endcase
        end
      end
      S_PREP: state_next = S_SPAN;
      S_SPAN: state_next = S_BOUNDS;
      S_BOUNDS: begin
        if (first_r >= 32'(end_r)) begin
          state_next = S_DONE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = fw_calc;
          state_next  = S_RANGE;
        end
      end
      S_RANGE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = wi;
        ram_wr_data = (mode_r == MODE_RESERVE) ? (ram_rd_data | range_mask)
                                               : (ram_rd_data & ~range_mask);
        if (wi == last_word) begin
          state_next = S_DONE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = wi + WIW'(1);
        end
      end
      S_ALLOC: begin
        if (words_r == '0) begin
          state_next = S_DONE;
        end else if (word_free) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = chk;
          ram_wr_data = ram_rd_data | (32'd1 << zb);
          state_next  = S_DONE;
        end else if (rd_pend && chk_last) begin
          state_next = S_DONE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = WIW'(scan);
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      wi       <= '0;
      fill_ack <= 1'b0;
      rd_pend  <= 1'b0;
      found    <= 1'b0;
      oom      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_FILL: begin
          if (wi != LAST_WORD) begin
            wi <= wi + WIW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_r   <= mode;
            addr_r   <= address;
            len_r    <= length;
            found    <= 1'b0;
            oom      <= 1'b0;
            rd_pend  <= 1'b0;
            scan     <= '0;
            words_r  <= words_calc;
            wi       <= '0;
            fill_ack <= 1'b1;
          end
        end
        S_PREP: begin
          first_r <= addr_r >> cfg.page_shift;
          case (mode_r)
            MODE_FREE:    count_r <= 33'd1;
            MODE_RESERVE: count_r <= ({1'b0, len_r} + {1'b0, page_mask}) >> cfg.page_shift;
            default:      count_r <= {1'b0, len_r >> cfg.page_shift};
          endcase
        end
        S_SPAN: begin
          end_r <= (end_sum > 34'(MAX_FRAMES)) ? MAX_END : FW'(end_sum);
        end
        S_BOUNDS: begin
          first_word <= fw_calc;
          wi         <= fw_calc;
          last_word  <= WIW'(last_frame >> 5);
          lo_bit     <= first_r[4:0];
          hi_bit     <= last_frame[4:0];
        end
        S_RANGE: begin
          if (wi != last_word) begin
            wi <= wi + WIW'(1);
          end
        end
        S_ALLOC: begin
          if (words_r == '0) begin
            oom <= 1'b1;
          end else if (word_free) begin
            found       <= 1'b1;
            found_frame <= {chk, zb};
          end else if (rd_pend && chk_last) begin
            oom <= 1'b1;
          end else begin
            chk     <= WIW'(scan);
            scan    <= scan + WCW'(1);
            rd_pend <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/bfa_checker.sv */
`default_nettype none

module bfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] frame_address,
  input logic        out_of_memory
);

  // The reset fill pass keeps commands out and no stale result shows.
  a_reset_fill: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("command port open or result shown right after reset");

  // Commands are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while one is in progress");

  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_memory |-> frame_address == 32'd0)
    else $error("exhausted allocation returned a nonzero address");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_address)
                               && $stable(out_of_memory))
    else $error("stalled result beat changed");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .frame_address (frame_address),
  .out_of_memory (out_of_memory)
);

`default_nettype wire
